### hdl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

   localparam int IDX_W = 6;   // covers the largest prefix store of 64 entries
   localparam int MIN_W = 7;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0] TAB_BYTE     = 8'h09;
   localparam logic [7:0] PRINT_LO     = 8'h20;
   localparam logic [7:0] PRINT_HI     = 8'h7E;

   localparam logic [MIN_W-1:0] MIN_LENGTH_RESET = 7'd4;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_RELEASE,
      CMD_PASS,
      CMD_NEWLINE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SHOW
   } back_state_type;

   function automatic logic is_text_byte(input logic [7:0] b);
      return (b == TAB_BYTE) || ((b >= PRINT_LO) && (b <= PRINT_HI));
   endfunction

endpackage

### hdl/pre_if.sv
// ----------------------------------------------------------------------------
// pre_if
// Valid/ready channels of the printable run extractor.
// ----------------------------------------------------------------------------
interface pre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface pre_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] min_length;

   modport source (output valid, output min_length, input ready);
   modport sink   (input valid, input min_length, output ready);
endinterface

### hdl/printable_run_extractor.sv
// ----------------------------------------------------------------------------
// printable_run_extractor
// Passes on runs of printable bytes that reach a minimum length.
// ----------------------------------------------------------------------------
// Channels: req_bus takes one byte (or an end-of-stream marker) per request;
// rsp_bus returns result bytes, with last set on the final result of a
// request; csr_bus writes min_length and is always ready. Write it only
// while the block is idle.
// A request is taken every cycle while the two-entry command queue has room.
// Pass-through bytes and closing newlines pass through the queue entry and
// the output register onto rsp_bus, one per cycle while the receiver is ready.
// A run that reaches min_length releases its held prefix as a burst of up to
// PREFIX_DEPTH results; each byte is fetched by the registered read of the
// prefix store in BK_READ and loaded into the output register in BK_SHOW
// before the next is read; requests keep arriving into the queue until it fills.
// When the receiver stalls, the result holds in the output register, the
// queue fills and req_bus.ready drops.
// Reset clears the run state and the queue and sets min_length to 4; the
// prefix store needs no clearing, since only entries of the current run are
// read.
// ----------------------------------------------------------------------------
module printable_run_extractor
   import pre_pkg::*;
#(
   parameter int PREFIX_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   pre_req_if.sink   req_bus,
   pre_rsp_if.source rsp_bus,
   pre_csr_if.sink   csr_bus
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head_cmd;

   pre_front #(
      .PREFIX_DEPTH(PREFIX_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (q_push_cmd)
   );

   pre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   pre_back #(
      .PREFIX_DEPTH(PREFIX_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

### hdl/pre_front.sv
// ----------------------------------------------------------------------------
// pre_front
// Accepts bytes, tracks the run state and issues commands to the back end.
// ----------------------------------------------------------------------------
module pre_front
   import pre_pkg::*;
#(
   parameter int PREFIX_DEPTH = 64
) (
   input  logic           clock,
   input  logic           reset,
   pre_req_if.sink        req_bus,
   pre_csr_if.sink        csr_bus,
   input  logic           q_full,
   output logic           q_push,
   output cmd_type        q_cmd
);

   localparam int CNT_W = $clog2(PREFIX_DEPTH + 1);

   logic [MIN_W-1:0] min_length_ff, min_length_in;
   logic [CNT_W-1:0] run_count_ff, run_count_in;
   logic             emitting_ff, emitting_in;
   logic [CNT_W-1:0] min_eff;
   logic [CNT_W-1:0] count_next;
   logic             accept;

   assign req_bus.ready = !q_full;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && !q_full;

   // saturate the minimum into 1..PREFIX_DEPTH
   always_comb begin
      if (min_length_ff == '0) begin
         min_eff = CNT_W'(1);
      end else if (min_length_ff > MIN_W'(PREFIX_DEPTH)) begin
         min_eff = CNT_W'(PREFIX_DEPTH);
      end else begin
         min_eff = CNT_W'(min_length_ff);
      end
   end

   assign count_next = run_count_ff + CNT_W'(1);

   always_comb begin
      min_length_in = min_length_ff;
      run_count_in  = run_count_ff;
      emitting_in   = emitting_ff;
      q_push        = 1'b0;
      q_cmd.kind    = CMD_STORE;
      q_cmd.idx     = IDX_W'(run_count_ff);
      q_cmd.data    = req_bus.data_byte;

      if (csr_bus.valid) begin
         min_length_in = csr_bus.min_length;
      end

      if (accept) begin
         if (req_bus.end_of_stream || !is_text_byte(req_bus.data_byte)) begin
            // close an emitted run, drop a short one
            q_push       = emitting_ff;
            q_cmd.kind   = CMD_NEWLINE;
            run_count_in = '0;
            emitting_in  = 1'b0;
         end else if (emitting_ff) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_PASS;
         end else begin
            q_push       = 1'b1;
            run_count_in = count_next;
            if (count_next >= min_eff) begin
               q_cmd.kind  = CMD_RELEASE;
               emitting_in = 1'b1;
            end else begin
               q_cmd.kind = CMD_STORE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         run_count_ff  <= '0;
         emitting_ff   <= 1'b0;
      end else begin
         min_length_ff <= min_length_in;
         run_count_ff  <= run_count_in;
         emitting_ff   <= emitting_in;
      end
   end

endmodule

### hdl/pre_queue.sv
// ----------------------------------------------------------------------------
// pre_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module pre_queue
   import pre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/pre_back.sv
// ----------------------------------------------------------------------------
// pre_back
// Executes commands: fills the prefix store, plays out bursts, drives results.
// ----------------------------------------------------------------------------
module pre_back
   import pre_pkg::*;
#(
   parameter int PREFIX_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  cmd_type   q_cmd,
   output logic      q_pop,
   pre_rsp_if.source rsp_bus
);

   localparam int ADDR_W = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;

   logic [7:0]       prefix_mem [PREFIX_DEPTH];
   logic [7:0]       rd_data_ff;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             out_free;
   logic             mem_wr;
   logic             mem_rd;

   assign out_free         = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.last     = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      last_idx_in  = last_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  CMD_STORE: begin
                     q_pop  = 1'b1;
                     mem_wr = 1'b1;
                  end
                  CMD_RELEASE: begin
                     q_pop       = 1'b1;
                     mem_wr      = 1'b1;
                     ptr_in      = '0;
                     last_idx_in = q_cmd.idx;
                     state_in    = BK_READ;
                  end
                  CMD_PASS, CMD_NEWLINE: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                        rsp_byte_in  = (q_cmd.kind == CMD_PASS) ? q_cmd.data : NEWLINE_BYTE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            mem_rd   = 1'b1;
            state_in = BK_SHOW;
         end
         BK_SHOW: begin
            // hold the fetched byte until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff;
               rsp_last_in  = (ptr_ff == last_idx_ff);
               if (ptr_ff == last_idx_ff) begin
                  state_in = BK_IDLE;
               end else begin
                  ptr_in   = ptr_ff + IDX_W'(1);
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      last_idx_ff <= last_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         prefix_mem[q_cmd.idx[ADDR_W-1:0]] <= q_cmd.data;
      end
      if (mem_rd) begin
         rd_data_ff <= prefix_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

endmodule

### tb/printable_run_checker.sv
// ----------------------------------------------------------------------------
// printable_run_checker
// Watches the request, result and register channels of the printable run
// extractor, keeps its own copy of the run state, and checks every result
// byte against the bytes it predicts, in order.
// ----------------------------------------------------------------------------
module printable_run_checker
   import pre_pkg::*;
#(
   parameter int PREFIX_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   pre_req_if   req_bus,
   pre_rsp_if   rsp_bus,
   pre_csr_if   csr_bus,
   output int   mismatch_count,
   output int   pending_count,
   output int   result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } out_beat_type;

   out_beat_type     expected_beats[$];
   logic [MIN_W-1:0] min_len_q;
   logic [6:0]       run_len;
   logic             emitting;
   logic [7:0]       held_bytes [PREFIX_DEPTH];
   int               errors;
   int               checked;

   function automatic int unsigned effective_min(input logic [MIN_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > PREFIX_DEPTH) return PREFIX_DEPTH;
      return int'(v);
   endfunction

   // Work out the bytes one request causes and queue them, last on the final one.
   task automatic predict_run_bytes(input logic [7:0] b, input logic eos);
      logic [7:0]   burst[$];
      logic         printable_b;
      out_beat_type beat;
      printable_b = (b == TAB_BYTE) || ((b >= PRINT_LO) && (b <= PRINT_HI));
      if (eos || !printable_b) begin
         if (emitting) burst.push_back(NEWLINE_BYTE);
         run_len  = '0;
         emitting = 1'b0;
      end else if (emitting) begin
         burst.push_back(b);
      end else begin
         if (int'(run_len) < PREFIX_DEPTH) begin
            held_bytes[run_len] = b;
            run_len = run_len + 7'd1;
         end
         if (int'(run_len) >= effective_min(min_len_q)) begin
            for (int i = 0; i < int'(run_len) && i < PREFIX_DEPTH; i++)
               burst.push_back(held_bytes[i]);
            emitting = 1'b1;
         end
      end
      for (int i = 0; i < burst.size(); i++) begin
         beat.out_byte = burst[i];
         beat.last     = (i == burst.size() - 1);
         expected_beats.push_back(beat);
      end
   endtask

   task automatic note_mismatch(input out_beat_type want, input out_beat_type got,
                                input bit orphan);
      if (errors < 10) begin
         if (orphan)
            $display("%0t: unexpected result byte %02h last %0b", $time,
                     got.out_byte, got.last);
         else
            $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.out_byte, want.last, got.out_byte, got.last);
      end
      errors++;
   endtask

   always @(posedge clock) begin
      out_beat_type got;
      out_beat_type want;
      if (reset) begin
         min_len_q = MIN_LENGTH_RESET;
         run_len   = '0;
         emitting  = 1'b0;
         errors    = 0;
         checked   = 0;
         expected_beats.delete();
      end else begin
         // Drain results first: a request taken at this edge cannot answer at it.
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.out_byte = rsp_bus.out_byte;
            got.last     = rsp_bus.last;
            checked++;
            if (expected_beats.size() == 0) begin
               want = '0;
               note_mismatch(want, got, 1'b1);
            end else begin
               want = expected_beats.pop_front();
               if (got.out_byte !== want.out_byte || got.last !== want.last)
                  note_mismatch(want, got, 1'b0);
            end
         end
         if (csr_bus.valid && csr_bus.ready)
            min_len_q = csr_bus.min_length;
         if (req_bus.valid && req_bus.ready)
            predict_run_bytes(req_bus.data_byte, req_bus.end_of_stream);
      end
      mismatch_count <= errors;
      pending_count  <= expected_beats.size();
      result_count   <= checked;
   end

endmodule

### tb/printable_run_extractor_test.sv
// ----------------------------------------------------------------------------
// printable_run_extractor_test
// Drives byte streams into the printable run extractor under random gaps and
// receiver stalls, across several min_length values, and reports the outcome
// of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module printable_run_extractor_test
   import pre_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 64;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 3000000;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   sent_count  = 0;
   int   write_count = 0;
   int   mismatch_count;
   int   pending_count;
   int   result_count;

   pre_req_if req_ch ();
   pre_rsp_if rsp_ch ();
   pre_csr_if csr_ch ();

   printable_run_extractor #(.PREFIX_DEPTH(DEPTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   printable_run_checker #(.PREFIX_DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_ch),
      .rsp_bus        (rsp_ch),
      .csr_bus        (csr_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("printable_run_extractor_test: FAIL");
         $finish;
      end
   end

   function automatic int req_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] printable_byte();
      if ($urandom_range(0, 9) == 0) return TAB_BYTE;
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] control_byte();
      int r;
      r = $urandom_range(0, 2);
      if (r == 0) return 8'($urandom_range(0, 8));
      if (r == 1) return 8'($urandom_range(10, 31));
      return 8'($urandom_range(127, 255));
   endfunction

   // Hold the request until taken, then idle for the given gap.
   task automatic send_req(input logic [7:0] b, input logic eos, input int gap);
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= b;
      req_ch.end_of_stream <= eos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_count++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_run(input int len, input bit steady);
      for (int i = 0; i < len; i++) send_req(printable_byte(), 1'b0, req_gap(steady));
   endtask

   // Stop sending until every predicted byte is out, then let the queue settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_length(input logic [MIN_W-1:0] v);
      csr_ch.valid      <= 1'b1;
      csr_ch.min_length <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      write_count++;
   endtask

   // Receiver: ready bursts with stalls, mostly short, now and then long.
   initial begin
      int burst;
      int gap;
      int r;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         r = $urandom_range(0, 99);
         burst = (r < 80) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(20, 60) : 1;
         repeat (burst) @(posedge clock);
         r = $urandom_range(0, 99);
         gap = (r < 70) ? $urandom_range(1, 2) : (r < 95) ? $urandom_range(3, 6)
                                                          : $urandom_range(20, 50);
         rsp_ch.ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   end

   initial begin
      logic [MIN_W-1:0] settings [7];
      int  eff;
      int  phase_items;
      int  r;
      int  len;
      int  term;
      bit  steady;

      settings = '{7'd1, 7'd5, 7'd127, 7'd0, 7'd3, 7'd64, 7'd2};

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= 8'h00;
      req_ch.end_of_stream <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.min_length    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed, default minimum of four: short run dropped by a control byte.
      send_req("A", 1'b0, req_gap(0));
      send_req("B", 1'b0, req_gap(0));
      send_req(8'h00, 1'b0, req_gap(0));
      // Run reaches the minimum on a tab, then extremes pass straight through.
      send_req("a", 1'b0, req_gap(0));
      send_req("b", 1'b0, req_gap(0));
      send_req("c", 1'b0, req_gap(0));
      send_req(TAB_BYTE, 1'b0, req_gap(0));
      send_req(PRINT_HI, 1'b0, req_gap(0));
      send_req(PRINT_LO, 1'b0, req_gap(0));
      send_req(8'h7F, 1'b0, req_gap(0));
      // End of stream outside an emitted run, with a printable byte to ignore.
      send_req("x", 1'b0, req_gap(0));
      send_req("y", 1'b0, req_gap(0));
      send_req("z", 1'b1, req_gap(0));
      // End of stream closing an emitted run.
      send_req("p", 1'b0, req_gap(0));
      send_req("q", 1'b0, req_gap(0));
      send_req("r", 1'b0, req_gap(0));
      send_req("s", 1'b0, req_gap(0));
      send_req(8'hFF, 1'b1, req_gap(0));
      send_req(8'h1F, 1'b0, req_gap(0));
      send_req(8'h80, 1'b0, req_gap(0));

      // Zero minimum acts as one.
      wait_idle();
      write_min_length(7'd0);
      send_req("1", 1'b0, req_gap(0));
      send_req("2", 1'b0, req_gap(0));
      send_req(NEWLINE_BYTE, 1'b0, req_gap(0));

      // Lower the minimum under a run already held.
      wait_idle();
      write_min_length(7'd8);
      send_req("a", 1'b0, req_gap(0));
      send_req("b", 1'b0, req_gap(0));
      send_req("c", 1'b0, req_gap(0));
      wait_idle();
      write_min_length(7'd2);
      send_req("d", 1'b0, req_gap(0));
      send_req(8'h00, 1'b1, req_gap(0));

      // Random part: mostly well-formed runs around the minimum, some noise.
      foreach (settings[s]) begin
         wait_idle();
         write_min_length(settings[s]);
         eff = (settings[s] == 0) ? 1 : (int'(settings[s]) > DEPTH) ? DEPTH : int'(settings[s]);
         if (int'(settings[s]) > DEPTH) begin
            // One run long enough to release the full prefix store.
            send_run(DEPTH + $urandom_range(0, 4), 1'b0);
            send_req(control_byte(), 1'b0, req_gap(0));
         end
         phase_items = 0;
         while (phase_items < 3) begin
            r      = $urandom_range(0, 99);
            steady = ($urandom_range(0, 4) == 0);
            if (r < 4) wait_idle();
            if (r < 18) begin
               send_req(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                        req_gap(steady));
               phase_items++;
            end else begin
               len = $urandom_range(1, ((eff > 8) ? 8 : eff) + 3);
               send_run(len, steady);
               phase_items += len;
               term = $urandom_range(0, 9);
               if (term < 2) begin
                  send_req(8'($urandom_range(0, 255)), 1'b1, req_gap(steady));
                  phase_items++;
               end else if (term < 9) begin
                  send_req(control_byte(), 1'b0, req_gap(steady));
                  phase_items++;
               end
            end
         end
      end

      wait_idle();
      $display("Sent %0d requests with %0d min_length writes; %0d result bytes checked.",
               sent_count, write_count, result_count);
      $display("Covered run release, pass-through, newline on control byte and end of stream.");
      if (mismatch_count == 0) begin
         $display("printable_run_extractor_test: PASS");
      end else begin
         $display("printable_run_extractor_test: FAIL");
      end
      $finish;
   end

endmodule
